// File: design/tcdp_pkg.sv
// Shared types and constants for the two-channel duration partition unit.
package tcdp_pkg;

    localparam int DUR_W = 12;
    localparam int CAP_W = 12;
    localparam int IDX_W = 6;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STATUS_PLACED      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SOLUTION = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW    = 2'd2;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last_item;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  item_index;
        logic              channel;
        logic [DUR_W-1:0]  start_time;
        logic [DUR_W-1:0]  end_time;
        logic              last_result;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ERR,
        ST_ROW_RD,
        ST_ROW_SET,
        ST_SWEEP,
        ST_DRAIN,
        ST_CHK_RD,
        ST_CHK,
        ST_F_RD,
        ST_F_LOOK,
        ST_F_DEC
    } state_t;

endpackage

// File: design/two_channel_duration_partition_unit.sv
// Top level: loads durations, fills the feasibility table, and places each item on a channel.
//
// Durations load at one transaction per cycle. The transaction flagged last_item starts a
// solve, and no input is accepted until the run's final result sits in the output register.
// The backward pass fills the table from the last stored row down to row 0 for clamped capacity
// c: one feasibility-table entry is written per cycle, with its two lookups into the row above read in
// the cycle before, plus setup states ROW_RD and ROW_SET and drain state DRAIN per row. A table check
// (CHK_RD, CHK) follows, then the forward rebuild places each item through F_RD, F_LOOK and F_DEC,
// held in F_DEC while m_ready stalls. A run rejected for too many items, or with no split, gives a
// single result from ST_ERR (overflow runs straight from ST_START, no-solution runs after the
// backward pass). The table is one bit memory of 2**clog2(MAX_ITEMS) rows (at least two) by
// 2**clog2(MAX_CAPACITY+1) columns with one write and two registered read ports; its row for the
// empty tail is implied (all ones), never stored, and no clearing pass is needed.
module two_channel_duration_partition_unit #(
    parameter int MAX_ITEMS    = 64,
    parameter int MAX_CAPACITY = 4095
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tcdp_pkg::CAP_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tcdp_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tcdp_pkg::out_t                     m_data
);

    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNW = $clog2(MAX_ITEMS + 1);
    localparam int CW  = $clog2(MAX_CAPACITY + 1);
    localparam int VW  = (CW > tcdp_pkg::DUR_W) ? CW : tcdp_pkg::DUR_W;
    localparam int SW  = VW + 1;
    localparam int PW  = $clog2(MAX_ITEMS * ((1 << tcdp_pkg::DUR_W) - 1) + 1);
    localparam int XW  = (PW > VW) ? PW : VW;
    localparam int AW  = IW + CW;
    localparam logic [VW-1:0]  MAXC    = VW'(MAX_CAPACITY);
    localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_ITEMS);

    tcdp_pkg::state_t state_reg, state_next;

    logic [tcdp_pkg::CAP_W-1:0]  cap_reg;
    logic [CNW-1:0]              cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic [PW-1:0]               tot_reg, tot_next;
    logic [PW-1:0]               pre_reg, pre_next;
    logic [PW-1:0]               lo_reg, lo_next;
    logic [VW-1:0]               hi_reg, hi_next;
    logic                        hi_ok_reg, hi_ok_next;
    logic [IW-1:0]               row_reg, row_next;
    logic                        top_reg, top_next;
    logic [CW-1:0]               s_reg, s_next;
    logic                        p_v_reg, p_v_next;
    logic [CW-1:0]               p_s_reg, p_s_next;
    logic                        p_a0_reg, p_a0_next;
    logic                        p_a1_reg, p_a1_next;
    logic [VW-1:0]               s1_reg, s1_next;
    logic [VW-1:0]               s2_reg, s2_next;
    logic [SW-1:0]               sum_reg, sum_next;
    logic                        fit_reg, fit_next;
    logic [tcdp_pkg::STAT_W-1:0] err_reg, err_next;
    tcdp_pkg::out_t              out_reg, out_next;
    logic                        m_valid_reg, m_valid_next;

    // duration store
    logic [tcdp_pkg::DUR_W-1:0] dur_mem [0:MAX_ITEMS-1];
    logic                       dur_we;
    logic [IW-1:0]              dur_wa;
    logic [tcdp_pkg::DUR_W-1:0] dur_q;

    // feasibility table: one write port, two read ports
    logic fe_mem [0:(1 << AW)-1];
    logic [AW-1:0] fa0, fa1, fwa;
    logic          fwe, fwd;
    logic          rd0_q, rd1_q;

    logic [VW-1:0] cap_eff;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] row_up;
    logic          out_free;

    assign cap_eff  = (VW'(cap_reg) > MAXC) ? MAXC : VW'(cap_reg);
    assign last_idx = IW'(cnt_reg - 1'b1);
    assign row_up   = IW'(row_reg + 1'b1);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tcdp_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign dur_we   = s_ready && s_valid && (cnt_reg < MAX_CNT);
    assign dur_wa   = IW'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (dur_we) begin
            dur_mem[dur_wa] <= s_data.duration;
        end
        dur_q <= dur_mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (fwe) begin
            fe_mem[fwa] <= fwd;
        end
        rd0_q <= fe_mem[fa0];
        rd1_q <= fe_mem[fa1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcdp_pkg::ST_IDLE;
            cap_reg     <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            tot_reg     <= '0;
            p_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            tot_reg     <= tot_next;
            p_v_reg     <= p_v_next;
            m_valid_reg <= m_valid_next;
        end
        pre_reg   <= pre_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        hi_ok_reg <= hi_ok_next;
        row_reg   <= row_next;
        top_reg   <= top_next;
        s_reg     <= s_next;
        p_s_reg   <= p_s_next;
        p_a0_reg  <= p_a0_next;
        p_a1_reg  <= p_a1_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        sum_reg   <= sum_next;
        fit_reg   <= fit_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    always_comb begin
        logic [XW-1:0] capx;
        logic [XW-1:0] prex;
        logic [XW-1:0] sx;
        logic [SW-1:0] sum_c;
        logic          ch0;

        capx = XW'(cap_eff);
        prex = XW'(pre_reg);
        sx   = XW'(s_reg);
        sum_c = SW'(s1_reg) + SW'(dur_q);
        ch0  = 1'b0;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        tot_next     = tot_reg;
        pre_next     = pre_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hi_ok_next   = hi_ok_reg;
        row_next     = row_reg;
        top_next     = top_reg;
        s_next       = s_reg;
        p_v_next     = 1'b0;
        p_s_next     = s_reg;
        p_a0_next    = 1'b0;
        p_a1_next    = 1'b0;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        sum_next     = sum_reg;
        fit_next     = fit_reg;
        err_next     = err_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        fa0 = {row_up, CW'(s_reg + CW'(dur_q))};
        fa1 = {row_up, s_reg};

        // write stage of the sweep: row i from two lookups into row i+1
        fwe = p_v_reg;
        fwa = {row_reg, p_s_reg};
        fwd = (p_a0_reg && (top_reg || rd0_q)) || (p_a1_reg && (top_reg || rd1_q));

        case (state_reg)
            tcdp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (cnt_reg < MAX_CNT) begin
                        cnt_next = cnt_reg + 1'b1;
                        tot_next = tot_reg + PW'(s_data.duration);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.last_item) begin
                        state_next = tcdp_pkg::ST_START;
                    end
                end
            end
            tcdp_pkg::ST_START: begin
                if (ovf_reg) begin
                    err_next   = tcdp_pkg::STATUS_OVERFLOW;
                    state_next = tcdp_pkg::ST_ERR;
                end else begin
                    row_next   = last_idx;
                    top_next   = 1'b1;
                    pre_next   = tot_reg;
                    state_next = tcdp_pkg::ST_ROW_RD;
                end
            end
            tcdp_pkg::ST_ROW_RD: begin
                // pre holds prefix[i+1] = prefix[i] + d here
                lo_next    = (prex > capx) ? PW'(prex - capx) : '0;
                state_next = tcdp_pkg::ST_ROW_SET;
            end
            tcdp_pkg::ST_ROW_SET: begin
                pre_next   = pre_reg - PW'(dur_q);
                hi_ok_next = VW'(dur_q) <= cap_eff;
                hi_next    = cap_eff - VW'(dur_q);
                s_next     = '0;
                state_next = tcdp_pkg::ST_SWEEP;
            end
            tcdp_pkg::ST_SWEEP: begin
                p_v_next  = 1'b1;
                p_a0_next = hi_ok_reg && (VW'(s_reg) <= hi_reg);
                p_a1_next = (sx <= prex) && (sx >= XW'(lo_reg));
                if (VW'(s_reg) == cap_eff) begin
                    state_next = tcdp_pkg::ST_DRAIN;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            tcdp_pkg::ST_DRAIN: begin
                if (row_reg == '0) begin
                    state_next = tcdp_pkg::ST_CHK_RD;
                end else begin
                    row_next   = row_reg - 1'b1;
                    top_next   = 1'b0;
                    state_next = tcdp_pkg::ST_ROW_RD;
                end
            end
            tcdp_pkg::ST_CHK_RD: begin
                fa1        = '0;
                state_next = tcdp_pkg::ST_CHK;
            end
            tcdp_pkg::ST_CHK: begin
                if (!rd1_q) begin
                    err_next   = tcdp_pkg::STATUS_NO_SOLUTION;
                    state_next = tcdp_pkg::ST_ERR;
                end else begin
                    row_next   = '0;
                    s1_next    = '0;
                    s2_next    = '0;
                    state_next = tcdp_pkg::ST_F_RD;
                end
            end
            tcdp_pkg::ST_F_RD: begin
                top_next   = (row_reg == last_idx);
                state_next = tcdp_pkg::ST_F_LOOK;
            end
            tcdp_pkg::ST_F_LOOK: begin
                sum_next   = sum_c;
                fit_next   = sum_c <= SW'(cap_eff);
                fa0        = {row_up, CW'(sum_c)};
                state_next = tcdp_pkg::ST_F_DEC;
            end
            tcdp_pkg::ST_F_DEC: begin
                // hold the lookup address so rd0_q stays valid through a stall
                fa0 = {row_up, CW'(sum_reg)};
                ch0 = fit_reg && (top_reg || rd0_q);
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    out_next.status      = tcdp_pkg::STATUS_PLACED;
                    out_next.item_index  = tcdp_pkg::IDX_W'(row_reg);
                    out_next.last_result = top_reg;
                    if (ch0) begin
                        out_next.channel    = 1'b0;
                        out_next.start_time = tcdp_pkg::DUR_W'(s1_reg);
                        out_next.end_time   = tcdp_pkg::DUR_W'(sum_reg);
                        s1_next             = VW'(sum_reg);
                    end else begin
                        out_next.channel    = 1'b1;
                        out_next.start_time = tcdp_pkg::DUR_W'(s2_reg);
                        out_next.end_time   = tcdp_pkg::DUR_W'(s2_reg + VW'(dur_q));
                        s2_next             = s2_reg + VW'(dur_q);
                    end
                    if (top_reg) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        tot_next   = '0;
                        state_next = tcdp_pkg::ST_IDLE;
                    end else begin
                        row_next   = row_up;
                        state_next = tcdp_pkg::ST_F_RD;
                    end
                end
            end
            tcdp_pkg::ST_ERR: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    out_next.status      = err_reg;
                    out_next.item_index  = '0;
                    out_next.channel     = 1'b0;
                    out_next.start_time  = '0;
                    out_next.end_time    = '0;
                    out_next.last_result = 1'b1;
                    cnt_next             = '0;
                    ovf_next             = 1'b0;
                    tot_next             = '0;
                    state_next           = tcdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
